// ===== rtl/core/mwsal_pkg.sv =====
// ----------------------------------------------------------------------------
// mwsal_pkg
// Shared widths, sequencer states and arithmetic unit codes for the
// shortest window sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package mwsal_pkg;

   localparam int VALUE_W  = 16;
   localparam int LENGTH_W = 11;
   localparam int TARGET_W = 26;

   localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVICT_RD,
      ST_EVICT_SUB,
      ST_APPEND,
      ST_CHECK,
      ST_SHRINK,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_CMP
   } alu_op_type;

endpackage

`default_nettype wire

// ===== rtl/core/mwsal_if.sv =====
// ----------------------------------------------------------------------------
// mwsal_if
// Valid/ready channels of the shortest window sum block: input words,
// result words and target register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwsal_req_if;
   logic                         valid;
   logic                         ready;
   logic [mwsal_pkg::VALUE_W-1:0] value;
   logic                         last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface mwsal_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mwsal_pkg::LENGTH_W-1:0] min_length;
   logic                          overflow;

   modport source (output valid, output min_length, output overflow, input ready);
   modport sink   (input valid, input min_length, input overflow, output ready);
endinterface

interface mwsal_csr_if;
   logic                          valid;
   logic                          ready;
   logic [mwsal_pkg::TARGET_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/min_window_sum_at_least_core.sv =====
// ----------------------------------------------------------------------------
// min_window_sum_at_least_core
// Shortest contiguous run whose sum reaches the target, over a word stream.
// Result: once the last word is appended and the window has shrunk while its
// sum reaches the target, the result word is loaded; it waits while rsp holds
// an earlier one. A new word is taken only in idle, after the previous one is
// checked; dropped values go through the shared adder and the RAM read.
// Reset: synchronous; clears the window, sum, best length and flag, target
// returns to 1. Window RAM is not cleared; only live entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module min_window_sum_at_least_core #(
   parameter int WINDOW_DEPTH = 1024,
   parameter int VALUE_BITS   = 16
) (
   input wire logic     clock,
   input wire logic     reset,
   mwsal_req_if.sink    req_ch,
   mwsal_rsp_if.source  rsp_ch,
   mwsal_csr_if.sink    csr_ch
);

   localparam int PTR_W   = $clog2(WINDOW_DEPTH);
   localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int WIDE_W  = ((VALUE_BITS + COUNT_W) > mwsal_pkg::TARGET_W)
                            ? (VALUE_BITS + COUNT_W) : mwsal_pkg::TARGET_W;
   localparam int SUM_W   = WIDE_W + 1;
   localparam int VEXT_W  = (VALUE_BITS > mwsal_pkg::VALUE_W) ? VALUE_BITS
                                                              : mwsal_pkg::VALUE_W;
   localparam int LEXT_W  = (COUNT_W > mwsal_pkg::LENGTH_W) ? COUNT_W
                                                            : mwsal_pkg::LENGTH_W;

   mwsal_pkg::state_type state_ff, state_in;

   logic [PTR_W-1:0]               head_ff, head_in;
   logic [PTR_W-1:0]               tail_ff, tail_in;
   logic [COUNT_W-1:0]             count_ff, count_in;
   logic [SUM_W-1:0]               sum_ff, sum_in;
   logic [COUNT_W-1:0]             best_ff, best_in;
   logic                           ovf_ff, ovf_in;
   logic [mwsal_pkg::TARGET_W-1:0] target_ff, target_in;
   logic [VALUE_BITS-1:0]          value_ff, value_in;
   logic                           last_ff, last_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [mwsal_pkg::LENGTH_W-1:0] rsp_len_ff, rsp_len_in;
   logic                           rsp_ovf_ff, rsp_ovf_in;

   logic [VEXT_W-1:0]       value_ext;
   logic [LEXT_W-1:0]       best_ext;
   logic [PTR_W-1:0]        head_next;
   logic [PTR_W-1:0]        tail_next;
   logic                    window_full;

   mwsal_pkg::alu_op_type   alu_op;
   logic [SUM_W-1:0]        alu_b;
   logic [SUM_W-1:0]        alu_result;
   logic                    alu_ge;

   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [VALUE_BITS-1:0]   ram_rd_data;

   mwsal_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (WINDOW_DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (head_ff),
      .wr_data (value_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (tail_ff),
      .rd_data (ram_rd_data)
   );

   mwsal_alu #(
      .WIDTH (SUM_W)
   ) u_alu (
      .op     (alu_op),
      .a      (sum_ff),
      .b      (alu_b),
      .result (alu_result),
      .ge     (alu_ge)
   );

   assign value_ext   = VEXT_W'(req_ch.value);
   assign best_ext    = LEXT_W'(best_ff);
   assign head_next   = (head_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
   assign tail_next   = (tail_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
   assign window_full = (count_ff == COUNT_W'(WINDOW_DEPTH));

   assign req_ch.ready      = (state_ff == mwsal_pkg::ST_IDLE);
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.min_length = rsp_len_ff;
   assign rsp_ch.overflow   = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      target_in    = target_ff;
      alu_op       = mwsal_pkg::ALU_CMP;
      alu_b        = SUM_W'(target_ff);
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      if (csr_ch.valid) begin
         target_in = csr_ch.data;
      end
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         mwsal_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               value_in = value_ext[VALUE_BITS-1:0];
               last_in  = req_ch.last;
               state_in = window_full ? mwsal_pkg::ST_EVICT_RD : mwsal_pkg::ST_APPEND;
            end
         end
         mwsal_pkg::ST_EVICT_RD: begin
            ram_rd_en = 1'b1;
            state_in  = mwsal_pkg::ST_EVICT_SUB;
         end
         mwsal_pkg::ST_EVICT_SUB: begin
            alu_op   = mwsal_pkg::ALU_SUB;
            alu_b    = SUM_W'(ram_rd_data);
            sum_in   = alu_result;
            tail_in  = tail_next;
            count_in = count_ff - COUNT_W'(1);
            ovf_in   = 1'b1;
            state_in = mwsal_pkg::ST_APPEND;
         end
         mwsal_pkg::ST_APPEND: begin
            ram_wr_en = 1'b1;
            alu_op    = mwsal_pkg::ALU_ADD;
            alu_b     = SUM_W'(value_ff);
            sum_in    = alu_result;
            head_in   = head_next;
            count_in  = count_ff + COUNT_W'(1);
            state_in  = mwsal_pkg::ST_CHECK;
         end
         mwsal_pkg::ST_CHECK: begin
            if ((count_ff != '0) && alu_ge) begin
               if ((best_ff == '0) || (count_ff < best_ff)) begin
                  best_in = count_ff;
               end
               ram_rd_en = 1'b1;
               state_in  = mwsal_pkg::ST_SHRINK;
            end else if (last_ff) begin
               state_in = mwsal_pkg::ST_FINISH;
            end else begin
               state_in = mwsal_pkg::ST_IDLE;
            end
         end
         mwsal_pkg::ST_SHRINK: begin
            alu_op   = mwsal_pkg::ALU_SUB;
            alu_b    = SUM_W'(ram_rd_data);
            sum_in   = alu_result;
            tail_in  = tail_next;
            count_in = count_ff - COUNT_W'(1);
            state_in = mwsal_pkg::ST_CHECK;
         end
         mwsal_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = best_ext[mwsal_pkg::LENGTH_W-1:0];
               rsp_ovf_in   = ovf_ff;
               head_in      = '0;
               tail_in      = '0;
               count_in     = '0;
               sum_in       = '0;
               best_in      = '0;
               ovf_in       = 1'b0;
               state_in     = mwsal_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mwsal_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwsal_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         target_ff    <= mwsal_pkg::TARGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      last_ff    <= last_in;
      rsp_len_ff <= rsp_len_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(WINDOW_DEPTH))
      else $error("window count exceeds depth");

   a_empty_pointers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mwsal_pkg::ST_IDLE && count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty window with unequal pointers");

   a_shrink_lowers_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mwsal_pkg::ST_SHRINK) |=> (sum_ff <= $past(sum_ff)))
      else $error("sum grew while dropping a word");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mwsal_pkg::ST_FINISH && (!rsp_valid_ff || rsp_ch.ready))
      |=> (rsp_valid_ff && count_ff == '0 && best_ff == '0 && sum_ff == '0))
      else $error("result loaded without clearing the sequence");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mwsal_ram.sv =====
// ----------------------------------------------------------------------------
// mwsal_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsal_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mwsal_alu.sv =====
// ----------------------------------------------------------------------------
// mwsal_alu
// Shared add, subtract and compare unit for the running window sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsal_alu #(
   parameter int WIDTH = 27
) (
   input  wire mwsal_pkg::alu_op_type op,
   input  wire logic [WIDTH-1:0]     a,
   input  wire logic [WIDTH-1:0]     b,
   output      logic [WIDTH-1:0]     result,
   output      logic                 ge
);

   logic [WIDTH-1:0] b_sel;
   logic             cin;
   logic             carry;

   always_comb begin
      unique case (op)
         mwsal_pkg::ALU_ADD: begin
            b_sel = b;
            cin   = 1'b0;
         end
         mwsal_pkg::ALU_SUB,
         mwsal_pkg::ALU_CMP: begin
            b_sel = ~b;
            cin   = 1'b1;
         end
         default: begin
            b_sel = b;
            cin   = 1'b0;
         end
      endcase
   end

   assign {carry, result} = {1'b0, a} + {1'b0, b_sel} + (WIDTH + 1)'(cin);
   assign ge = carry;

endmodule

`default_nettype wire

// ===== sim/mwsal_checker.sv =====
// ----------------------------------------------------------------------------
// mwsal_checker
// Watches the word, result and target channels of the shortest window sum
// block. It tracks the window, the sum and the best length of each
// sequence, queues the result due on every last word, and compares each
// result word with the oldest one queued.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsal_checker #(
   parameter int DEPTH = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   mwsal_req_if      req_ch,
   mwsal_rsp_if      rsp_ch,
   mwsal_csr_if      csr_ch,
   output int        fail_count,
   output int        pending
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int VAL_W = mwsal_pkg::VALUE_W;
   localparam int LEN_W = mwsal_pkg::LENGTH_W;
   localparam int TGT_W = mwsal_pkg::TARGET_W;

   typedef struct packed {
      logic [LEN_W-1:0] min_length;
      logic             overflow;
   } run_result_type;

   logic [VAL_W-1:0]  ring [DEPTH];
   logic [PTR_W-1:0]  head_slot;
   logic [PTR_W-1:0]  tail_slot;
   logic [LEN_W-1:0]  held;
   logic [TGT_W-1:0]  run_sum;
   logic [LEN_W-1:0]  best_len;
   logic              spilled;
   logic [TGT_W-1:0]  target_q;
   run_result_type    expected_runs [$];
   int                mismatches = 0;

   assign fail_count = mismatches;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic clear_run();
      head_slot = '0;
      tail_slot = '0;
      held      = '0;
      run_sum   = '0;
      best_len  = '0;
      spilled   = 1'b0;
   endtask

   task automatic drop_oldest();
      run_sum   = run_sum - TGT_W'(ring[tail_slot]);
      tail_slot = advance(tail_slot);
      held      = held - LEN_W'(1);
   endtask

   task automatic absorb_word(input logic [VAL_W-1:0] v, input logic is_last);
      run_result_type r;
      if (held >= LEN_W'(DEPTH)) begin
         drop_oldest();
         spilled = 1'b1;
      end
      ring[head_slot] = v;
      head_slot = advance(head_slot);
      held      = held + LEN_W'(1);
      run_sum   = run_sum + TGT_W'(v);
      while (held != 0 && run_sum >= target_q) begin
         if (best_len == 0 || held < best_len)
            best_len = held;
         drop_oldest();
      end
      if (is_last) begin
         r.min_length = best_len;
         r.overflow   = spilled;
         expected_runs = {expected_runs, r};
         clear_run();
      end
   endtask

   always @(posedge clock) begin
      run_result_type got;
      run_result_type want;
      if (reset) begin
         clear_run();
         target_q = mwsal_pkg::TARGET_RESET;
         expected_runs.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready)
            target_q = csr_ch.data;
         if (req_ch.valid && req_ch.ready)
            absorb_word(req_ch.value, req_ch.last);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.min_length = rsp_ch.min_length;
            got.overflow   = rsp_ch.overflow;
            if (expected_runs.size() == 0) begin
               report($sformatf("result word with none due: length %0d overflow %0b",
                                got.min_length, got.overflow));
            end else begin
               want = expected_runs.pop_front();
               if (got.min_length !== want.min_length)
                  report($sformatf("min_length %0d, expected %0d",
                                   got.min_length, want.min_length));
               if (got.overflow !== want.overflow)
                  report($sformatf("overflow %0b, expected %0b",
                                   got.overflow, want.overflow));
            end
         end
      end
      pending <= expected_runs.size();
   end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression for min_window_sum_at_least_core. Drives directed sequences,
// one long sequence that overruns the window, then random sequences under
// several targets and idle patterns, with one long result hold-off. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int VAL_W        = mwsal_pkg::VALUE_W;
   localparam int TGT_W        = mwsal_pkg::TARGET_W;
   localparam int DEPTH        = 1024;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 20000;
   localparam int PHASES       = 12;
   localparam int PHASE_WORDS  = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_req      = 1'b0;
   int   quiet_cycles  = 0;
   int   fail_count;
   int   pending;

   mwsal_req_if req_bus ();
   mwsal_rsp_if rsp_bus ();
   mwsal_csr_if csr_bus ();

   min_window_sum_at_least_core #(
      .WINDOW_DEPTH (DEPTH),
      .VALUE_BITS   (VAL_W)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   mwsal_checker #(
      .DEPTH (DEPTH)
   ) watch (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_bus),
      .rsp_ch     (rsp_bus),
      .csr_ch     (csr_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("min_window_sum_at_least_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, or a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req)
            hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_word(input logic [VAL_W-1:0] v, input logic is_last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      req_bus.last  <= is_last;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   // hold input until every result is back, then let the block settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_target(input logic [TGT_W-1:0] t);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= t;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return VAL_W'($urandom_range(0, 15));
         4, 5:    return VAL_W'($urandom_range(0, 1023));
         default: return VAL_W'($urandom());
      endcase
   endfunction

   initial begin
      logic [TGT_W-1:0] t;
      int               len;
      int               sent;
      bit               paused;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      req_bus.last  <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset target of one
      send_word(16'd5, 1'b1);
      send_word(16'd0, 1'b1);
      send_word(16'd0, 1'b0);
      send_word(16'hAAAA, 1'b0);
      send_word(16'h5555, 1'b1);
      drain();
      write_target(26'd100);
      send_word(16'hFFFF, 1'b1);
      repeat (3) send_word(16'd30, 1'b0);
      send_word(16'd30, 1'b1);
      send_word(16'd10, 1'b0);
      send_word(16'd20, 1'b0);
      send_word(16'd30, 1'b1);
      send_word(16'd60, 1'b0);
      send_word(16'd0, 1'b0);
      send_word(16'd50, 1'b0);
      send_word(16'd0, 1'b0);
      send_word(16'd0, 1'b0);
      send_word(16'd60, 1'b1);
      drain();
      // zero target: every word qualifies alone
      write_target('0);
      send_word(16'd3, 1'b0);
      send_word(16'd0, 1'b0);
      send_word(16'd9, 1'b1);
      drain();
      write_target('1);
      send_word(16'hFFFF, 1'b0);
      send_word(16'hFFFF, 1'b1);
      drain();

      // overrun the window with small words, then reach the target with full ones
      write_target(26'd65535000);
      for (int i = 0; i < DEPTH + 6; i++) begin
         if (i < 30)
            send_word(VAL_W'($urandom_range(0, 100)), 1'b0);
         else
            send_word('1, i == DEPTH + 5);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph % 6)
            0:       t = TGT_W'($urandom_range(1, 64));
            1:       t = TGT_W'($urandom_range(1000, 200000));
            2:       t = TGT_W'($urandom_range(65536, 1000000));
            3:       t = TGT_W'(1);
            4:       t = TGT_W'($urandom_range(1, 67108863));
            default: t = '1;
         endcase
         write_target(t);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_idle_pct = 84; rsp_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct <= 84; end
            default: begin send_idle_pct = 24; rsp_stall_pct <= 24; end
         endcase
         if (ph == 4) begin
            hold_req <= 1'b1;
            @(posedge clock);
            hold_req <= 1'b0;
         end
         sent   = 0;
         paused = 1'b0;
         while (sent < PHASE_WORDS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                              : $urandom_range(1, 12);
            if (PHASE_WORDS - sent < len + 3)
               len = PHASE_WORDS - sent;
            for (int i = 0; i < len; i++)
               send_word(pick_value(), i == len - 1);
            sent += len;
            if (ph == 6 && sent >= PHASE_WORDS / 2 && !paused) begin
               drain();
               paused = 1'b1;
            end
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("min_window_sum_at_least_core regression: pass");
      else
         $display("min_window_sum_at_least_core regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
